[sv/efpr_pkg.sv]
// ----------------------------------------------------------------------------
// efpr_pkg: shared types and constants
// Byte codes, register indexes and the job record passed from the frame
// parser to the write emitter.
// ----------------------------------------------------------------------------
package efpr_pkg;

  localparam int unsigned NUM_CHANNELS_DEF = 16;
  localparam int unsigned JOB_DEPTH        = 2;
  localparam int unsigned PAYLOAD_KEEP     = 5;

  localparam logic [7:0] START_BYTE = 8'h7A;
  localparam logic [7:0] ESC_BYTE   = 8'h7B;
  localparam logic [7:0] ESC_CODE0  = 8'h00;
  localparam logic [7:0] ESC_CODE1  = 8'h01;

  localparam logic [2:0] TYPE_WIDE  = 3'd6;

  // configuration register indexes
  localparam logic [1:0] REG_NODE_ID       = 2'd0;
  localparam logic [1:0] REG_CHANNEL_COUNT = 2'd1;
  localparam logic [1:0] REG_CHANNEL_TYPES = 2'd2;

  typedef struct packed {
    logic [7:0]  node_id;
    logic [4:0]  channel_count;
    logic [47:0] channel_types;
  } cfg_t;

  // one accepted frame: channel, index of its final byte, value bytes
  typedef struct packed {
    logic [3:0]      channel;
    logic [1:0]      last_idx;
    logic [3:0][7:0] value;
  } job_t;

  // index of the final byte write for a channel type:
  // type 6 is four bytes, otherwise 1 << (type mod 3) bytes
  function automatic logic [1:0] last_index(input logic [2:0] ch_type);
    logic [1:0] res;
    res = 2'd0;
    case (ch_type)
      3'd0, 3'd3:       res = 2'd0;
      3'd1, 3'd4, 3'd7: res = 2'd1;
      default:          res = 2'd3;  // 2, 5 and TYPE_WIDE
    endcase
    return res;
  endfunction

endpackage

[sv/escaped_frame_param_receiver.sv]
// ----------------------------------------------------------------------------
// escaped_frame_param_receiver: byte-stuffed parameter frame receiver
// Rebuilds escaped link frames and turns accepted parameter frames into
// byte writes for one channel.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue write port: raw link bytes on rx_byte_i are taken
//   at each edge with push high and full low, one byte per cycle. full only
//   rises while the job queue holds two frames whose writes are not yet out.
//   Result side is a queue read port: while empty is low the oldest byte
//   write (channel_o, byte_offset_o, byte_value_o, last_write_o) is shown
//   and is taken at an edge with pop high. A frame gives 1, 2 or 4 writes,
//   one per cycle while pop stays high, the last flagged by last_write_o;
//   rejected frames give none. With the emitter idle, the job of a frame is
//   written into the queue at the edge that takes its completing byte and
//   then moves into the emitter register, which shows its first write. A
//   stalled reader holds the current write; the parser keeps taking bytes
//   until the two-entry job queue fills.
//   The configuration channel (cfg_valid_i/cfg_ready_o) is always ready;
//   write it only while the block is idle.
//   Reset clears the parser, the queues, the configuration registers and
//   the five stored data bytes, which are kept across frames afterwards.
// ----------------------------------------------------------------------------
module escaped_frame_param_receiver #(
  parameter int unsigned NumChannels = efpr_pkg::NUM_CHANNELS_DEF,
  parameter int unsigned JobDepth    = efpr_pkg::JOB_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // link byte input
  input  logic        push,
  output logic        full,
  input  logic [7:0]  rx_byte_i,
  // byte write results
  output logic        empty,
  input  logic        pop,
  output logic [3:0]  channel_o,
  output logic [1:0]  byte_offset_o,
  output logic [7:0]  byte_value_o,
  output logic        last_write_o,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [47:0] cfg_data_i
);
  import efpr_pkg::*;

  cfg_t cfg_q;

  logic byte_take;
  logic job_push;
  job_t job_in;
  job_t job_out;
  logic fifo_full;
  logic fifo_empty;
  logic job_take;

  // configuration registers, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_NODE_ID:       cfg_q.node_id       <= cfg_data_i[7:0];
        REG_CHANNEL_COUNT: cfg_q.channel_count <= cfg_data_i[4:0];
        REG_CHANNEL_TYPES: cfg_q.channel_types <= cfg_data_i;
        default: ;  // unmapped index, ignored
      endcase
    end
  end

  // a byte is only taken when a completing frame is sure to find queue room
  assign full      = fifo_full;
  assign byte_take = push && !fifo_full;

  efpr_front #(
    .NumChannels (NumChannels)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (byte_take),
    .byte_i      (rx_byte_i),
    .cfg_i       (cfg_q),
    .job_valid_o (job_push),
    .job_o       (job_in)
  );

  efpr_job_fifo #(
    .Depth (JobDepth)
  ) u_job_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .wdata_i (job_in),
    .pop_i   (job_take),
    .rdata_o (job_out),
    .full_o  (fifo_full),
    .empty_o (fifo_empty)
  );

  efpr_emitter u_emitter (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_avail_i   (!fifo_empty),
    .job_i         (job_out),
    .job_take_o    (job_take),
    .pop_i         (pop),
    .empty_o       (empty),
    .channel_o     (channel_o),
    .byte_offset_o (byte_offset_o),
    .byte_value_o  (byte_value_o),
    .last_write_o  (last_write_o)
  );

  // a job is only ever pushed into a queue with room
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_push |-> !fifo_full)
    else $error("job queue overflow");

  // a write that is not the last is followed by the next byte of the value
  a_offset_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty && !last_write_o) |=>
      (!empty && byte_offset_o == $past(byte_offset_o) + 2'd1))
    else $error("byte offset did not advance within a frame");

  // a burst that starts from empty starts at offset zero
  a_burst_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(empty) |-> (byte_offset_o == 2'd0))
    else $error("write burst did not start at offset zero");

endmodule

[sv/efpr_front.sv]
// ----------------------------------------------------------------------------
// efpr_front: frame parser
// Unescapes link bytes, tracks the header and data bytes and, on frame
// completion, checks id and channel and hands a write job to the queue.
// ----------------------------------------------------------------------------
module efpr_front #(
  parameter int unsigned NumChannels = efpr_pkg::NUM_CHANNELS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [7:0]        byte_i,
  input  efpr_pkg::cfg_t    cfg_i,
  output logic              job_valid_o,
  output efpr_pkg::job_t    job_o
);
  import efpr_pkg::*;

  logic                  in_frame_q, in_frame_d;
  logic                  esc_q, esc_d;
  logic [16:0]           count_q, count_d;
  logic [7:0]            id_q, id_d;
  logic [15:0]           len_q, len_d;
  logic [PAYLOAD_KEEP-1:0][7:0] pay_q, pay_d;

  logic [16:0] cnt_inc;
  logic [7:0]  data_byte;
  logic        take;
  logic        done;
  logic [7:0]  ch;
  logic [2:0]  ch_type;
  logic        ch_ok;
  logic [2:0]  slot;

  assign cnt_inc = count_q + 17'd1;
  assign ch      = pay_d[0];
  assign ch_type = cfg_i.channel_types[6'(ch[3:0]) * 6'd3 +: 3];
  assign ch_ok   = (ch < {3'b000, cfg_i.channel_count}) && (ch < 8'(NumChannels));
  assign slot    = 3'(cnt_inc - 17'd6);

  always_comb begin
    in_frame_d = in_frame_q;
    esc_d      = esc_q;
    count_d    = count_q;
    id_d       = id_q;
    len_d      = len_q;
    pay_d      = pay_q;
    take       = 1'b0;
    data_byte  = byte_i;
    done       = 1'b0;

    if (valid_i) begin
      if (byte_i == START_BYTE) begin
        in_frame_d = 1'b1;
        esc_d      = 1'b0;
        count_d    = 17'd1;
        id_d       = '0;
        len_d      = '0;
      end else if (byte_i == ESC_BYTE) begin
        esc_d = 1'b1;
      end else if (esc_q) begin
        esc_d = 1'b0;
        if (byte_i == ESC_CODE0 || byte_i == ESC_CODE1) begin
          take      = in_frame_q;
          data_byte = byte_i[0] ? ESC_BYTE : START_BYTE;
        end else begin
          // bad escape aborts the frame
          in_frame_d = 1'b0;
          count_d    = '0;
          id_d       = '0;
          len_d      = '0;
        end
      end else begin
        take = in_frame_q;
      end
    end

    if (take) begin
      count_d = cnt_inc;
      case (cnt_inc)
        17'd2: ;  // frame type, not used
        17'd3: id_d = data_byte;
        17'd4: len_d[7:0]  = data_byte;
        17'd5: len_d[15:8] = data_byte;
        default: begin
          if (cnt_inc <= 17'd10) begin
            pay_d[slot] = data_byte;
          end
          if (cnt_inc >= {1'b0, len_q} + 17'd5) begin
            done       = 1'b1;
            in_frame_d = 1'b0;
            esc_d      = 1'b0;
            count_d    = '0;
            id_d       = '0;
            len_d      = '0;
          end
        end
      endcase
    end
  end

  assign job_valid_o    = done && (id_q == cfg_i.node_id) && ch_ok;
  assign job_o.channel  = ch[3:0];
  assign job_o.last_idx = last_index(ch_type);
  assign job_o.value    = {pay_d[4], pay_d[3], pay_d[2], pay_d[1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      esc_q      <= 1'b0;
      count_q    <= '0;
      id_q       <= '0;
      len_q      <= '0;
      pay_q      <= '0;
    end else begin
      in_frame_q <= in_frame_d;
      esc_q      <= esc_d;
      count_q    <= count_d;
      id_q       <= id_d;
      len_q      <= len_d;
      pay_q      <= pay_d;
    end
  end

endmodule

[sv/efpr_job_fifo.sv]
// ----------------------------------------------------------------------------
// efpr_job_fifo: job queue
// Short queue of write jobs between the frame parser and the emitter.
// ----------------------------------------------------------------------------
module efpr_job_fifo #(
  parameter int unsigned Depth = efpr_pkg::JOB_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  efpr_pkg::job_t wdata_i,
  input  logic           pop_i,
  output efpr_pkg::job_t rdata_o,
  output logic           full_o,
  output logic           empty_o
);
  import efpr_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + CntW'(1);
        2'b01:   cnt_q <= cnt_q - CntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

[sv/efpr_emitter.sv]
// ----------------------------------------------------------------------------
// efpr_emitter: write emitter
// Holds one job and presents its byte writes one at a time on the
// result side.
// ----------------------------------------------------------------------------
module efpr_emitter (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           job_avail_i,
  input  efpr_pkg::job_t job_i,
  output logic           job_take_o,
  input  logic           pop_i,
  output logic           empty_o,
  output logic [3:0]     channel_o,
  output logic [1:0]     byte_offset_o,
  output logic [7:0]     byte_value_o,
  output logic           last_write_o
);
  import efpr_pkg::*;

  logic       active_q;
  logic [1:0] idx_q;
  job_t       job_q;
  logic       taken;
  logic       last;

  assign last       = (idx_q == job_q.last_idx);
  assign taken      = active_q && pop_i;
  assign job_take_o = job_avail_i && (!active_q || (taken && last));

  assign empty_o       = !active_q;
  assign channel_o     = job_q.channel;
  assign byte_offset_o = idx_q;
  assign byte_value_o  = job_q.value[idx_q];
  assign last_write_o  = last;

  always_ff @(posedge clk_i) begin
    if (job_take_o) begin
      job_q <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      idx_q    <= '0;
    end else begin
      if (job_take_o) begin
        active_q <= 1'b1;
        idx_q    <= '0;
      end else if (taken) begin
        if (last) begin
          active_q <= 1'b0;
        end else begin
          idx_q <= idx_q + 2'd1;
        end
      end
    end
  end

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: escaped frame parameter receiver
// Feeds escaped link bytes through the push/full port and checks every byte
// write popped from the result port against a cycle-free model of the frame
// decoder. A short directed table comes first, then random frames under four
// register settings, with random gaps on both sides and one long reader stall.
// ----------------------------------------------------------------------------
module testbench;
  import efpr_pkg::*;

  // what a directed row expects from the DUT
  typedef enum logic [1:0] {
    CHK_MODEL,  // whatever the model predicts
    CHK_NONE,   // no write at all
    CHK_ONE     // exactly the single write typed into the row
  } row_chk_e;

  // one byte write as seen on the result port
  typedef struct packed {
    logic [3:0] channel;
    logic [1:0] offset;
    logic [7:0] value;
    logic       last;
  } bw_t;

  typedef struct packed {
    logic [7:0] rx;
    row_chk_e   chk;
    bw_t        wr;
  } stim_row_t;

  localparam int DIR_ROWS      = 28;
  localparam int DIR_SPLIT     = 6;   // registers get rewritten before this row
  localparam int SETTLE_CYCLES = 8;   // parser + job queue + emitter, with margin
  localparam int DRAIN_CYCLES  = 20;
  localparam int LONG_HOLD     = 80;  // reader stall long enough to fill the job queue

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic [7:0]  rx_byte_i;
  logic        empty;
  logic        pop;
  logic [3:0]  channel_o;
  logic [1:0]  byte_offset_o;
  logic [7:0]  byte_value_o;
  logic        last_write_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [47:0] cfg_data_i;

  escaped_frame_param_receiver u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .rx_byte_i     (rx_byte_i),
    .empty         (empty),
    .pop           (pop),
    .channel_o     (channel_o),
    .byte_offset_o (byte_offset_o),
    .byte_value_o  (byte_value_o),
    .last_write_o  (last_write_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Decoder model: register copy, frame state and the five kept data bytes
  // --------------------------------------------------------------------------
  logic [7:0]  cfg_node;
  logic [4:0]  cfg_count;
  logic [47:0] cfg_types;

  logic        rx_open;     // inside a frame
  logic        esc_armed;   // escape byte seen, waiting for its code
  logic [16:0] frame_pos;   // start byte is position 1
  logic [7:0]  hdr_type;
  logic [7:0]  hdr_id;
  logic [15:0] data_len;
  logic [7:0]  data_keep [PAYLOAD_KEEP];  // survives across frames

  bw_t model_out [4];       // writes caused by the last decoded byte
  bw_t pending_writes [$];  // writes still owed by the DUT, oldest first

  int  n_err;
  int  n_items;
  int  n_predicted;
  bit  tx_burst;            // sender drops its gaps
  int  hold_requests;       // bumped by the stimulus, served by the reader

  function automatic void drop_frame();
    rx_open   = 1'b0;
    esc_armed = 1'b0;
    frame_pos = '0;
    hdr_type  = '0;
    hdr_id    = '0;
    data_len  = '0;
  endfunction

  // one unescaped byte inside a frame; returns the number of writes it causes
  function automatic int store_byte(input logic [7:0] b);
    int         n;
    int         chi;
    logic [2:0] ctype;
    n = 0;
    frame_pos = frame_pos + 17'd1;
    case (frame_pos)
      17'd2: hdr_type = b;
      17'd3: hdr_id = b;
      17'd4: data_len[7:0] = b;
      17'd5: data_len[15:8] = b;
      default: begin
        if (frame_pos >= 17'd6 && frame_pos - 17'd6 < PAYLOAD_KEEP)
          data_keep[frame_pos - 17'd6] = b;
        // length counts data bytes, but at least one always comes
        if (frame_pos >= {1'b0, data_len} + 17'd5) begin
          chi = data_keep[0];
          if (hdr_id == cfg_node && chi < cfg_count && chi < NUM_CHANNELS_DEF) begin
            ctype = cfg_types[3 * chi +: 3];
            n = (ctype == TYPE_WIDE) ? 4 : (1 << (ctype % 3));
            for (int i = 0; i < n; i++) begin
              model_out[i].channel = chi[3:0];
              model_out[i].offset  = i[1:0];
              model_out[i].value   = data_keep[i + 1];
              model_out[i].last    = (i == n - 1);
            end
          end
          drop_frame();
        end
      end
    endcase
    return n;
  endfunction

  // one raw link byte
  function automatic int decode_byte(input logic [7:0] b);
    int n;
    n = 0;
    if (b == START_BYTE) begin
      // a start byte always opens a fresh frame, even mid-frame
      drop_frame();
      rx_open   = 1'b1;
      frame_pos = 17'd1;
    end else if (b == ESC_BYTE) begin
      esc_armed = 1'b1;  // also while idle, and a repeat keeps it armed
    end else if (esc_armed) begin
      esc_armed = 1'b0;
      if (b == ESC_CODE0 || b == ESC_CODE1) begin
        if (rx_open) n = store_byte(START_BYTE + b);
      end else begin
        drop_frame();    // bad escape aborts
      end
    end else if (rx_open) begin
      n = store_byte(b);
    end
    return n;
  endfunction

  function automatic void cmp_field(input string what, input logic [7:0] want,
                                    input logic [7:0] got);
    if (got !== want) begin
      n_err++;
      $display("%0t: %s expected %0h, got %0h", $time, what, want, got);
    end
  endfunction

  function automatic stim_row_t mk_row(input logic [7:0] b, input row_chk_e c,
                                       input bw_t w);
    stim_row_t r;
    r.rx  = b;
    r.chk = c;
    r.wr  = w;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Sender: one request per byte, random gap before each unless bursting.
  // push is left high after acceptance; the next call or the caller lowers it
  // in the same time step, so a held push is never dropped and re-raised.
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input row_chk_e chk, input bw_t typed);
    int gap;
    int n;
    gap = tx_burst ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push      <= 1'b1;
    rx_byte_i <= b;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    // bytes that only fall on an idle decoder do not count as work
    if (rx_open || esc_armed || b == START_BYTE || b == ESC_BYTE) n_items++;
    n = decode_byte(b);
    case (chk)
      CHK_MODEL: begin
        for (int i = 0; i < n; i++) pending_writes.push_back(model_out[i]);
        n_predicted += n;
      end
      CHK_ONE: begin
        pending_writes.push_back(typed);
        n_predicted++;
      end
      default: ;
    endcase
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [47:0] val);
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_NODE_ID:       cfg_node  = val[7:0];
      REG_CHANNEL_COUNT: cfg_count = val[4:0];
      REG_CHANNEL_TYPES: cfg_types = val;
      default: ;
    endcase
  endtask

  // waits for the block to go quiet, then rewrites all three registers
  task automatic apply_cfg(input logic [7:0] node, input logic [4:0] count,
                           input logic [47:0] types);
    push <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk_i);
    // a rejected frame may still be in the pipe with nothing owed
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_write(REG_NODE_ID, {40'd0, node});
    cfg_write(REG_CHANNEL_COUNT, {43'd0, count});
    cfg_write(REG_CHANNEL_TYPES, types);
    cfg_valid_i <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Random frame. clean = well formed, matching id, valid channel, short.
  // Otherwise: some noise, foreign ids and channels, huge lengths, frames cut
  // short (the next start byte ends them) and bad escapes.
  // --------------------------------------------------------------------------
  task automatic random_frame(input bit clean);
    logic [7:0]  body [$];
    logic [15:0] flen;
    logic [7:0]  bad;
    int          ndata;
    int          stop_at;
    int          bad_at;
    if (!clean && $urandom_range(0, 99) < 8) begin
      repeat ($urandom_range(1, 3)) send_byte($urandom_range(0, 255), CHK_MODEL, '0);
      return;
    end
    if (!clean) tx_burst = ($urandom_range(0, 3) == 0);
    if (clean) flen = $urandom_range(0, 2);
    else if ($urandom_range(0, 19) < 17) flen = $urandom_range(0, 6);
    else flen = $urandom_range(0, 65535);
    body.push_back($urandom_range(0, 255));
    body.push_back((clean || $urandom_range(0, 3) != 0) ? cfg_node : $urandom_range(0, 255));
    body.push_back(flen[7:0]);
    body.push_back(flen[15:8]);
    if (clean || $urandom_range(0, 7) != 0)
      body.push_back($urandom_range(0, (cfg_count == 0) ? 0 : cfg_count - 1));
    else
      body.push_back($urandom_range(0, 255));
    // up to six data bytes, so the one past the kept five shows up too
    ndata = (flen == 0) ? 1 : ((flen > 6) ? 6 : flen);
    for (int k = 1; k < ndata; k++) begin
      if ($urandom_range(0, 5) == 0)
        body.push_back($urandom_range(0, 1) ? START_BYTE : ESC_BYTE);
      else
        body.push_back($urandom_range(0, 255));
    end
    stop_at = body.size();
    if (!clean && (flen > 6 || $urandom_range(0, 9) == 0))
      stop_at = $urandom_range(0, body.size() - 1);
    bad_at = (!clean && $urandom_range(0, 14) == 0) ? $urandom_range(0, stop_at) : -1;

    send_byte(START_BYTE, CHK_MODEL, '0);
    for (int k = 0; k < stop_at && k != bad_at; k++) begin
      if (body[k] == START_BYTE || body[k] == ESC_BYTE) begin
        // now and then a doubled escape, which stays armed
        if ($urandom_range(0, 7) == 0) send_byte(ESC_BYTE, CHK_MODEL, '0);
        send_byte(ESC_BYTE, CHK_MODEL, '0);
        send_byte((body[k] == START_BYTE) ? ESC_CODE0 : ESC_CODE1, CHK_MODEL, '0);
      end else begin
        send_byte(body[k], CHK_MODEL, '0);
      end
    end
    if (bad_at >= 0) begin
      bad = $urandom_range(0, 255);
      if (bad == ESC_CODE0 || bad == ESC_CODE1 || bad == START_BYTE || bad == ESC_BYTE)
        bad = 8'h55;
      send_byte(ESC_BYTE, CHK_MODEL, '0);
      send_byte(bad, CHK_MODEL, '0);
    end
  endtask

  // --------------------------------------------------------------------------
  // Reader: checks each popped write against the oldest one owed, then draws
  // a random stall. Bursts without stalls come and go at random.
  // A hold request from the stimulus turns into one long stall.
  // Outputs are read right after the edge, i.e. as they were at the edge.
  // --------------------------------------------------------------------------
  initial begin
    int  stall;
    int  holds_done;
    bit  rx_burst;
    bw_t want;
    stall      = 0;
    holds_done = 0;
    rx_burst   = 1'b0;
    pop <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        if (pending_writes.size() == 0) begin
          n_err++;
          $display("%0t: write with none owed: ch %0d off %0d val %0h last %0b",
                   $time, channel_o, byte_offset_o, byte_value_o, last_write_o);
        end else begin
          want = pending_writes.pop_front();
          cmp_field("channel", want.channel, channel_o);
          cmp_field("byte_offset", want.offset, byte_offset_o);
          cmp_field("byte_value", want.value, byte_value_o);
          cmp_field("last_write", want.last, last_write_o);
        end
        if ($urandom_range(0, 15) == 0) rx_burst = ~rx_burst;
        stall = rx_burst ? 0 : $urandom_range(0, 5);
      end
      if (holds_done != hold_requests) begin
        holds_done++;
        stall = LONG_HOLD;
      end
      if (stall > 0) begin
        pop <= 1'b0;
        stall--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    stim_row_t dir_tbl [DIR_ROWS];
    int        goal;

    push        <= 1'b0;
    rx_byte_i   <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i  <= '0;
    rst_ni      <= 1'b0;

    n_err         = 0;
    n_items       = 0;
    n_predicted   = 0;
    tx_burst      = 1'b0;
    hold_requests = 0;
    cfg_node      = '0;
    cfg_count     = '0;
    cfg_types     = '0;
    drop_frame();
    for (int i = 0; i < PAYLOAD_KEEP; i++) data_keep[i] = '0;

    // rows 0..5 run with all registers zero, the rest with node 0xFF,
    // all 16 channels, channel 2 four bytes wide and channel 15 one byte
    dir_tbl = '{
      // zero channel count: a well-formed frame with length 0 is rejected
      mk_row(START_BYTE, CHK_NONE, '0), mk_row(8'h00, CHK_NONE, '0),
      mk_row(8'h00, CHK_NONE, '0), mk_row(8'h00, CHK_NONE, '0),
      mk_row(8'h00, CHK_NONE, '0), mk_row(8'h00, CHK_NONE, '0),
      // escape while idle, doubled, then its code: all swallowed
      mk_row(ESC_BYTE, CHK_NONE, '0), mk_row(ESC_BYTE, CHK_NONE, '0),
      mk_row(ESC_CODE1, CHK_NONE, '0),
      // restart mid-frame, then a bad escape aborts the new frame
      mk_row(START_BYTE, CHK_NONE, '0), mk_row(8'h44, CHK_NONE, '0),
      mk_row(START_BYTE, CHK_NONE, '0), mk_row(ESC_BYTE, CHK_NONE, '0),
      mk_row(8'h33, CHK_NONE, '0),
      // max id, length 1, channel 15 (one byte): value byte never received,
      // so the write carries the zero left from reset
      mk_row(START_BYTE, CHK_NONE, '0), mk_row(8'h00, CHK_NONE, '0),
      mk_row(8'hFF, CHK_NONE, '0), mk_row(8'h01, CHK_NONE, '0),
      mk_row(8'h00, CHK_NONE, '0),
      mk_row(8'h0F, CHK_ONE, {4'd15, 2'd0, 8'h00, 1'b1}),
      // four-byte channel, escaped data byte, rest of the value left over
      mk_row(START_BYTE, CHK_MODEL, '0), mk_row(8'h00, CHK_MODEL, '0),
      mk_row(8'hFF, CHK_MODEL, '0), mk_row(8'h02, CHK_MODEL, '0),
      mk_row(8'h00, CHK_MODEL, '0), mk_row(8'h02, CHK_MODEL, '0),
      mk_row(ESC_BYTE, CHK_MODEL, '0), mk_row(ESC_CODE1, CHK_MODEL, '0)
    };

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    apply_cfg(8'h00, 5'd0, 48'h0);
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (i == DIR_SPLIT) apply_cfg(8'hFF, 5'd16, 48'h0000_0000_0F80);
      send_byte(dir_tbl[i].rx, dir_tbl[i].chk, dir_tbl[i].wr);
    end

    for (int p = 0; p < 4; p++) begin
      case (p)
        // node id equal to the start byte: every matching id goes out escaped;
        // all types 7, so two-byte writes
        0: apply_cfg(START_BYTE, 5'd16, 48'hFFFF_FFFF_FFFF);
        1: apply_cfg(8'h00, 5'd1, 48'h0);
        2: apply_cfg($urandom_range(0, 255), $urandom_range(0, 16), {$urandom, $urandom});
        default: apply_cfg(8'hFF, 5'd16, {4{12'hDB6}});  // every channel wide
      endcase
      if (p == 3) begin
        // reader holds off while clean frames stream in back to back,
        // so the job queue fills and full must stall the sender
        hold_requests++;
        tx_burst = 1'b1;
        repeat (5) random_frame(1'b1);
        tx_burst = 1'b0;
      end
      goal = n_items + 45;
      while (n_items < goal || (p == 3 && n_predicted < 48)) random_frame(1'b0);
    end

    push <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (n_err == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // hard stop, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule

[sim.f]
sv/efpr_pkg.sv
sv/efpr_front.sv
sv/efpr_job_fifo.sv
sv/efpr_emitter.sv
sv/escaped_frame_param_receiver.sv
bench/testbench.sv
